// File: design/cpt_pkg.sv
`timescale 1ns / 1ps

package cpt_pkg;

    // Quotient bits below the saturation point of the rounded offset
    localparam int QUO_BITS = 62;

    // Digit width of the digit-per-stage multipliers
    localparam int DIG_BITS = 17;

    typedef enum logic [1:0] {
        RGN_FACE   = 2'd0,
        RGN_EDGE   = 2'd1,
        RGN_VERTEX = 2'd2,
        RGN_NONE   = 2'd3
    } region_t;

endpackage

// File: design/cpt_dly.sv
`timescale 1ns / 1ps

module cpt_dly #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] line_reg [DEPTH];

    // Shift the side data along with the arithmetic stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                line_reg[i] <= '0;
            end
        end else if (en) begin
            line_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++) begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign q = line_reg[DEPTH-1];

endmodule

// File: design/cpt_mul.sv
`timescale 1ns / 1ps

module cpt_mul import cpt_pkg::*; #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output logic signed [AW+BW-1:0] p
);

    localparam int NDIG = (BW + DIG_BITS - 1) / DIG_BITS;
    localparam int BPW  = NDIG * DIG_BITS;
    localparam int PW   = AW + BW;

    logic signed [AW-1:0] a_reg   [NDIG];
    logic [BPW-1:0]       b_reg   [NDIG];
    logic signed [PW-1:0] acc_reg [NDIG];

    // One digit of b per stage; the top digit carries the sign
    for (genvar j = 0; j < NDIG; j++) begin : g_dig
        logic signed [AW-1:0]         a_in;
        logic [BPW-1:0]               b_in;
        logic signed [PW-1:0]         acc_in;
        logic signed [AW+DIG_BITS:0]  pp;
        logic signed [PW-1:0]         acc_next;

        if (j == 0) begin : g_first
            assign a_in   = a;
            assign b_in   = BPW'(b);
            assign acc_in = '0;
        end else begin : g_next
            assign a_in   = a_reg[j-1];
            assign b_in   = b_reg[j-1];
            assign acc_in = acc_reg[j-1];
        end

        always_comb begin
            if (j == NDIG - 1) begin
                pp = a_in * $signed(b_in[j*DIG_BITS +: DIG_BITS]);
            end else begin
                pp = a_in * $signed({1'b0, b_in[j*DIG_BITS +: DIG_BITS]});
            end
            acc_next = acc_in + (PW'(pp) <<< (j * DIG_BITS));
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                a_reg[j]   <= a_in;
                b_reg[j]   <= b_in;
                acc_reg[j] <= acc_next;
            end
        end
    end

    assign p = acc_reg[NDIG-1];

endmodule

// File: design/cpt_div.sv
`timescale 1ns / 1ps

module cpt_div import cpt_pkg::*; #(
    parameter int NW = 64,
    parameter int DW = 32
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [NW-1:0]     n,
    input  logic [DW-1:0]     d,
    output logic [QUO_BITS:0] q
);

    localparam int CW  = ((NW > DW + QUO_BITS) ? NW : DW + QUO_BITS) + 1;
    localparam int NST = QUO_BITS + 1;

    logic [CW-1:0]       rem_reg [NST];
    logic [DW-1:0]       den_reg [NST];
    logic [QUO_BITS-1:0] quo_reg [NST];
    logic                sat_reg [NST];

    for (genvar j = 0; j < NST; j++) begin : g_stage
        if (j == 0) begin : g_sat
            // Flag a quotient at or above the saturation point
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[0] <= CW'(n);
                    den_reg[0] <= d;
                    quo_reg[0] <= '0;
                    sat_reg[0] <= CW'(n) >= (CW'(d) << QUO_BITS);
                end
            end
        end else begin : g_bit
            logic [CW-1:0] shifted;
            logic          take;

            // Restore-divide one quotient bit, most significant first
            always_comb begin
                shifted = CW'(den_reg[j-1]) << (QUO_BITS - j);
                take    = rem_reg[j-1] >= shifted;
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j] <= take ? rem_reg[j-1] - shifted : rem_reg[j-1];
                    den_reg[j] <= den_reg[j-1];
                    quo_reg[j] <= quo_reg[j-1]
                        | (take ? (QUO_BITS'(1) << (QUO_BITS - j)) : '0);
                    sat_reg[j] <= sat_reg[j-1];
                end
            end
        end
    end

    assign q = sat_reg[NST-1] ? ((QUO_BITS+1)'(1) << QUO_BITS)
                              : {1'b0, quo_reg[NST-1]};

endmodule

// File: design/closest_point_on_triangle.sv
`timescale 1ns / 1ps
// Closest point on a triangle to a query point.
// Input channel (s_valid/s_ready): vertices A, B, C and point P, signed
// fixed point, COORD_BITS per coordinate. Result channel (m_valid/m_ready):
// the closest point, saturated to COORD_BITS, and the region code
// (face, edge, vertex, or none when no region test holds).
// Throughput: one request per cycle while the output is not stalled.
// Order: edge and offset vectors, coordinate products, dot products, area
// multipliers, area terms, region select, offset multipliers, dividend, the
// 63-stage restoring divider that rounds the offset along the edge or face
// (saturation flag, then one quotient bit per stage), output register.
// Reset: synchronous, active low; it clears every valid bit, so the
// pipeline comes up empty and m_valid low.
// Stall: while m_valid is high and m_ready low the whole pipeline holds
// and s_ready drops; nothing is lost or repeated. Results leave in the
// order the requests arrived.
module closest_point_on_triangle import cpt_pkg::*; #(
    parameter int COORD_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_ax,
    input  logic [COORD_BITS-1:0] s_ay,
    input  logic [COORD_BITS-1:0] s_az,
    input  logic [COORD_BITS-1:0] s_bx,
    input  logic [COORD_BITS-1:0] s_by_coord,
    input  logic [COORD_BITS-1:0] s_bz,
    input  logic [COORD_BITS-1:0] s_cx,
    input  logic [COORD_BITS-1:0] s_cy,
    input  logic [COORD_BITS-1:0] s_cz,
    input  logic [COORD_BITS-1:0] s_px,
    input  logic [COORD_BITS-1:0] s_py,
    input  logic [COORD_BITS-1:0] s_pz,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COORD_BITS-1:0] m_near_x,
    output logic [COORD_BITS-1:0] m_near_y,
    output logic [COORD_BITS-1:0] m_near_z,
    output logic [1:0]            m_region
);

    localparam int W    = COORD_BITS;
    localparam int DW   = W + 1;
    localparam int DOTW = 2 * DW + 2;
    localparam int VW   = 2 * DOTW + 1;
    localparam int DENW = VW + 2;
    localparam int NW   = VW + DW + 1;
    localparam int SUMW = QUO_BITS + 3;
    localparam int L1   = (DOTW + DIG_BITS - 1) / DIG_BITS;
    localparam int L2   = (VW + DIG_BITS - 1) / DIG_BITS;
    localparam int SC1W = 1 + 6 * DOTW + 9 * DW + 9 * W;
    localparam int SC2W = 1 + 3 * W + DENW + 2;
    localparam int SC3W = 1 + 3 + 1 + 3 * W + 2;
    localparam logic signed [SUMW-1:0] SAT_HI = (SUMW'(1) << (W - 1)) - SUMW'(1);
    localparam logic signed [SUMW-1:0] SAT_LO = -SAT_HI - SUMW'(1);

    logic adv;

    // Advance every stage unless the output holds a result not yet taken
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // ---------------- Stage 1: edge and offset vectors
    logic [2:0][W-1:0] a_in, b_in, c_in, p_in;
    logic              v1_reg;
    logic [2:0][W-1:0] a1_reg, b1_reg, c1_reg;
    logic [2:0][DW-1:0] ab1_reg, ac1_reg, bc1_reg, ap1_reg, bp1_reg, cp1_reg;

    assign a_in = {s_az, s_ay, s_ax};
    assign b_in = {s_bz, s_by_coord, s_bx};
    assign c_in = {s_cz, s_cy, s_cx};
    assign p_in = {s_pz, s_py, s_px};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                a1_reg[k]  <= a_in[k];
                b1_reg[k]  <= b_in[k];
                c1_reg[k]  <= c_in[k];
                ab1_reg[k] <= DW'($signed(b_in[k])) - DW'($signed(a_in[k]));
                ac1_reg[k] <= DW'($signed(c_in[k])) - DW'($signed(a_in[k]));
                bc1_reg[k] <= DW'($signed(c_in[k])) - DW'($signed(b_in[k]));
                ap1_reg[k] <= DW'($signed(p_in[k])) - DW'($signed(a_in[k]));
                bp1_reg[k] <= DW'($signed(p_in[k])) - DW'($signed(b_in[k]));
                cp1_reg[k] <= DW'($signed(p_in[k])) - DW'($signed(c_in[k]));
            end
        end
    end

    // ---------------- Stage 2: coordinate products of the six dot products
    logic [5:0][2:0][2*DW-1:0] pr2_next, pr2_reg;
    logic               v2_reg;
    logic [2:0][W-1:0]  a2_reg, b2_reg, c2_reg;
    logic [2:0][DW-1:0] ab2_reg, ac2_reg, bc2_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pr2_next[0][k] = $signed(ab1_reg[k]) * $signed(ap1_reg[k]);
            pr2_next[1][k] = $signed(ac1_reg[k]) * $signed(ap1_reg[k]);
            pr2_next[2][k] = $signed(ab1_reg[k]) * $signed(bp1_reg[k]);
            pr2_next[3][k] = $signed(ac1_reg[k]) * $signed(bp1_reg[k]);
            pr2_next[4][k] = $signed(ab1_reg[k]) * $signed(cp1_reg[k]);
            pr2_next[5][k] = $signed(ac1_reg[k]) * $signed(cp1_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pr2_reg <= pr2_next;
            a2_reg  <= a1_reg;
            b2_reg  <= b1_reg;
            c2_reg  <= c1_reg;
            ab2_reg <= ab1_reg;
            ac2_reg <= ac1_reg;
            bc2_reg <= bc1_reg;
        end
    end

    // ---------------- Stage 3: dot products d1..d6
    logic [5:0][DOTW-1:0] dot3_next, dot3_reg;
    logic               v3_reg;
    logic [2:0][W-1:0]  a3_reg, b3_reg, c3_reg;
    logic [2:0][DW-1:0] ab3_reg, ac3_reg, bc3_reg;

    always_comb begin
        for (int n = 0; n < 6; n++) begin
            dot3_next[n] = DOTW'($signed(pr2_reg[n][0])) + DOTW'($signed(pr2_reg[n][1]))
                         + DOTW'($signed(pr2_reg[n][2]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dot3_reg <= dot3_next;
            a3_reg   <= a2_reg;
            b3_reg   <= b2_reg;
            c3_reg   <= c2_reg;
            ab3_reg  <= ab2_reg;
            ac3_reg  <= ac2_reg;
            bc3_reg  <= bc2_reg;
        end
    end

    // ---------------- Area-term products, one digit per stage
    logic signed [2*DOTW-1:0] am [6];

    cpt_mul #(.AW(DOTW), .BW(DOTW)) u_mul_a0 (.aclk, .en(adv),
        .a($signed(dot3_reg[2])), .b($signed(dot3_reg[5])), .p(am[0]));
    cpt_mul #(.AW(DOTW), .BW(DOTW)) u_mul_a1 (.aclk, .en(adv),
        .a($signed(dot3_reg[4])), .b($signed(dot3_reg[3])), .p(am[1]));
    cpt_mul #(.AW(DOTW), .BW(DOTW)) u_mul_a2 (.aclk, .en(adv),
        .a($signed(dot3_reg[4])), .b($signed(dot3_reg[1])), .p(am[2]));
    cpt_mul #(.AW(DOTW), .BW(DOTW)) u_mul_a3 (.aclk, .en(adv),
        .a($signed(dot3_reg[0])), .b($signed(dot3_reg[5])), .p(am[3]));
    cpt_mul #(.AW(DOTW), .BW(DOTW)) u_mul_a4 (.aclk, .en(adv),
        .a($signed(dot3_reg[0])), .b($signed(dot3_reg[3])), .p(am[4]));
    cpt_mul #(.AW(DOTW), .BW(DOTW)) u_mul_a5 (.aclk, .en(adv),
        .a($signed(dot3_reg[2])), .b($signed(dot3_reg[1])), .p(am[5]));

    logic [SC1W-1:0]      sc1_q;
    logic                 v_m1;
    logic [5:0][DOTW-1:0] dot_m1;
    logic [2:0][DW-1:0]   ab_m1, ac_m1, bc_m1;
    logic [2:0][W-1:0]    a_m1, b_m1, c_m1;

    cpt_dly #(.WIDTH(SC1W), .DEPTH(L1)) u_dly_m1 (
        .aclk, .aresetn, .en(adv),
        .d({v3_reg, dot3_reg, ab3_reg, ac3_reg, bc3_reg, a3_reg, b3_reg, c3_reg}),
        .q(sc1_q)
    );

    assign {v_m1, dot_m1, ab_m1, ac_m1, bc_m1, a_m1, b_m1, c_m1} = sc1_q;

    // ---------------- Stage 4: area terms va, vb, vc and edge terms
    logic                    v4_reg;
    logic signed [VW-1:0]    va4_reg, vb4_reg, vc4_reg;
    logic signed [DOTW:0]    e43_4_reg, e56_4_reg;
    logic [5:0][DOTW-1:0]    dot4_reg;
    logic [2:0][DW-1:0]      ab4_reg, ac4_reg, bc4_reg;
    logic [2:0][W-1:0]       a4_reg, b4_reg, c4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= v_m1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            va4_reg   <= VW'(am[0]) - VW'(am[1]);
            vb4_reg   <= VW'(am[2]) - VW'(am[3]);
            vc4_reg   <= VW'(am[4]) - VW'(am[5]);
            e43_4_reg <= (DOTW+1)'($signed(dot_m1[3])) - (DOTW+1)'($signed(dot_m1[2]));
            e56_4_reg <= (DOTW+1)'($signed(dot_m1[4])) - (DOTW+1)'($signed(dot_m1[5]));
            dot4_reg  <= dot_m1;
            ab4_reg   <= ab_m1;
            ac4_reg   <= ac_m1;
            bc4_reg   <= bc_m1;
            a4_reg    <= a_m1;
            b4_reg    <= b_m1;
            c4_reg    <= c_m1;
        end
    end

    // ---------------- Stage 5: region select in priority order
    logic                  va_ge, vb_ge, vc_ge, va_le, vb_le, vc_le;
    logic                  d1_ge, d1_le, d2_ge, d2_le, d3_ge, d3_le, d6_ge, d6_le;
    logic                  e43_ge, e43_le, e56_ge, e56_le;
    logic [2:0][W-1:0]     base5_next, base5_reg;
    logic signed [VW-1:0]  m1_5_next, m2_5_next, m1_5_reg, m2_5_reg;
    logic [2:0][DW-1:0]    dir1_5_next, dir2_5_next, dir1_5_reg, dir2_5_reg;
    logic signed [DENW-1:0] den5_next, den5_reg;
    region_t               rgn5_next, rgn5_reg;
    logic                  v5_reg;

    always_comb begin
        va_ge  = !va4_reg[VW-1];
        vb_ge  = !vb4_reg[VW-1];
        vc_ge  = !vc4_reg[VW-1];
        va_le  = va4_reg[VW-1] || (va4_reg == '0);
        vb_le  = vb4_reg[VW-1] || (vb4_reg == '0);
        vc_le  = vc4_reg[VW-1] || (vc4_reg == '0);
        d1_ge  = !dot4_reg[0][DOTW-1];
        d1_le  = dot4_reg[0][DOTW-1] || (dot4_reg[0] == '0);
        d2_ge  = !dot4_reg[1][DOTW-1];
        d2_le  = dot4_reg[1][DOTW-1] || (dot4_reg[1] == '0);
        d3_ge  = !dot4_reg[2][DOTW-1];
        d3_le  = dot4_reg[2][DOTW-1] || (dot4_reg[2] == '0);
        d6_ge  = !dot4_reg[5][DOTW-1];
        d6_le  = dot4_reg[5][DOTW-1] || (dot4_reg[5] == '0);
        e43_ge = !e43_4_reg[DOTW];
        e43_le = e43_4_reg[DOTW] || (e43_4_reg == '0);
        e56_ge = !e56_4_reg[DOTW];
        e56_le = e56_4_reg[DOTW] || (e56_4_reg == '0);

        base5_next  = '0;
        m1_5_next   = '0;
        m2_5_next   = '0;
        dir1_5_next = '0;
        dir2_5_next = '0;
        den5_next   = '0;
        rgn5_next   = RGN_NONE;

        if (va_ge && vb_ge && vc_ge) begin
            rgn5_next   = RGN_FACE;
            base5_next  = a4_reg;
            m1_5_next   = vb4_reg;
            dir1_5_next = ab4_reg;
            m2_5_next   = vc4_reg;
            dir2_5_next = ac4_reg;
            den5_next   = DENW'(va4_reg) + DENW'(vb4_reg) + DENW'(vc4_reg);
        end else if (d6_ge && e56_le) begin
            rgn5_next  = RGN_VERTEX;
            base5_next = c4_reg;
        end else if (d3_ge && e43_le) begin
            rgn5_next  = RGN_VERTEX;
            base5_next = b4_reg;
        end else if (d1_le && d2_le) begin
            rgn5_next  = RGN_VERTEX;
            base5_next = a4_reg;
        end else if (va_le && e43_ge && e56_ge) begin
            rgn5_next   = RGN_EDGE;
            base5_next  = b4_reg;
            m1_5_next   = VW'(e43_4_reg);
            dir1_5_next = bc4_reg;
            den5_next   = DENW'(e43_4_reg) + DENW'(e56_4_reg);
        end else if (vb_le && d2_ge && d6_le) begin
            rgn5_next   = RGN_EDGE;
            base5_next  = a4_reg;
            m1_5_next   = VW'($signed(dot4_reg[1]));
            dir1_5_next = ac4_reg;
            den5_next   = DENW'($signed(dot4_reg[1])) - DENW'($signed(dot4_reg[5]));
        end else if (vc_le && d1_ge && d3_le) begin
            rgn5_next   = RGN_EDGE;
            base5_next  = a4_reg;
            m1_5_next   = VW'($signed(dot4_reg[0]));
            dir1_5_next = ab4_reg;
            den5_next   = DENW'($signed(dot4_reg[0])) - DENW'($signed(dot4_reg[2]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (adv) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            base5_reg  <= base5_next;
            m1_5_reg   <= m1_5_next;
            m2_5_reg   <= m2_5_next;
            dir1_5_reg <= dir1_5_next;
            dir2_5_reg <= dir2_5_next;
            den5_reg   <= den5_next;
            rgn5_reg   <= rgn5_next;
        end
    end

    // ---------------- Offset numerator products per coordinate
    // Step through digits of the wide factor so each stage stays narrow
    logic signed [VW+DW-1:0] q1 [3];
    logic signed [VW+DW-1:0] q2 [3];

    for (genvar k = 0; k < 3; k++) begin : g_num
        cpt_mul #(.AW(DW), .BW(VW)) u_mul_n1 (.aclk, .en(adv),
            .a($signed(dir1_5_reg[k])), .b(m1_5_reg), .p(q1[k]));
        cpt_mul #(.AW(DW), .BW(VW)) u_mul_n2 (.aclk, .en(adv),
            .a($signed(dir2_5_reg[k])), .b(m2_5_reg), .p(q2[k]));
    end

    logic [SC2W-1:0]        sc2_q;
    logic                   v_m2;
    logic [2:0][W-1:0]      base_m2;
    logic signed [DENW-1:0] den_m2;
    region_t                rgn_m2;

    cpt_dly #(.WIDTH(SC2W), .DEPTH(L2)) u_dly_m2 (
        .aclk, .aresetn, .en(adv),
        .d({v5_reg, base5_reg, den5_reg, rgn5_reg}),
        .q(sc2_q)
    );

    assign v_m2    = sc2_q[SC2W-1];
    assign base_m2 = sc2_q[SC2W-2 -: 3*W];
    assign den_m2  = sc2_q[DENW+1:2];
    assign rgn_m2  = region_t'(sc2_q[1:0]);

    // ---------------- Stage 6: rounding dividend and divisor
    logic signed [NW-1:0]     num6 [3];
    logic [NW-1:0]            abs6 [3];
    logic [2:0][NW+1:0]       n6_next, n6_reg;
    logic [2:0]               neg6_next, neg6_reg;
    logic [DENW:0]            dv6_reg;
    logic                     dnz6_reg, v6_reg;
    logic [2:0][W-1:0]        base6_reg;
    region_t                  rgn6_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            num6[k]      = NW'(q1[k]) + NW'(q2[k]);
            neg6_next[k] = num6[k][NW-1];
            abs6[k]      = neg6_next[k] ? NW'(-num6[k]) : NW'(num6[k]);
            n6_next[k]   = ((NW+2)'(abs6[k]) << 1) + (NW+2)'(den_m2);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (adv) begin
            v6_reg <= v_m2;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            n6_reg    <= n6_next;
            neg6_reg  <= neg6_next;
            dv6_reg   <= {den_m2, 1'b0};
            dnz6_reg  <= den_m2 != '0;
            base6_reg <= base_m2;
            rgn6_reg  <= rgn_m2;
        end
    end

    // ---------------- Rounded quotient, one bit per stage
    logic [QUO_BITS:0] mag [3];

    for (genvar k = 0; k < 3; k++) begin : g_div
        cpt_div #(.NW(NW+2), .DW(DENW+1)) u_div (
            .aclk, .en(adv), .n(n6_reg[k]), .d(dv6_reg), .q(mag[k])
        );
    end

    logic [SC3W-1:0]   sc3_q;
    logic              v_dv, dnz_dv;
    logic [2:0]        neg_dv;
    logic [2:0][W-1:0] base_dv;
    region_t           rgn_dv;

    cpt_dly #(.WIDTH(SC3W), .DEPTH(QUO_BITS+1)) u_dly_dv (
        .aclk, .aresetn, .en(adv),
        .d({v6_reg, neg6_reg, dnz6_reg, base6_reg, rgn6_reg}),
        .q(sc3_q)
    );

    assign v_dv    = sc3_q[SC3W-1];
    assign neg_dv  = sc3_q[SC3W-2 -: 3];
    assign dnz_dv  = sc3_q[3*W+2];
    assign base_dv = sc3_q[3*W+1:2];
    assign rgn_dv  = region_t'(sc3_q[1:0]);

    // ---------------- Output register: add offset and saturate
    logic signed [SUMW-1:0] off7 [3];
    logic signed [SUMW-1:0] sum7 [3];
    logic [2:0][W-1:0]      near_next, near_reg;
    logic                   m_valid_reg;
    region_t                rgn_out_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            off7[k] = neg_dv[k] ? -SUMW'(mag[k]) : SUMW'(mag[k]);
            sum7[k] = SUMW'($signed(base_dv[k])) + (dnz_dv ? off7[k] : SUMW'(0));
            if (sum7[k] > SAT_HI) begin
                near_next[k] = SAT_HI[W-1:0];
            end else if (sum7[k] < SAT_LO) begin
                near_next[k] = SAT_LO[W-1:0];
            end else begin
                near_next[k] = sum7[k][W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= v_dv;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            near_reg    <= near_next;
            rgn_out_reg <= rgn_dv;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_near_x = near_reg[0];
    assign m_near_y = near_reg[1];
    assign m_near_z = near_reg[2];
    assign m_region = rgn_out_reg;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench import cpt_pkg::*;;

    localparam int CW         = 32;
    localparam int WATCH_MAX  = 4000;
    localparam int DRAIN_WAIT = 200;

    typedef logic signed [255:0] wide_t;

    // One request: ax ay az bx by bz cx cy cz px py pz
    typedef struct {
        logic signed [CW-1:0] v [12];
        bit                   drain_first;
    } tri_req_t;

    typedef struct {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        region_t       rgn;
    } near_pt_t;

    logic          aclk;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    logic [CW-1:0] s_coord [12];
    logic          m_valid;
    logic          m_ready;
    logic [CW-1:0] m_near_x;
    logic [CW-1:0] m_near_y;
    logic [CW-1:0] m_near_z;
    logic [1:0]    m_region;

    tri_req_t pending_reqs[$];
    near_pt_t expected_pts[$];
    int       n_sent;
    int       n_recv;
    int       n_fail;
    int       idle_cycles;

    closest_point_on_triangle #(.COORD_BITS(CW)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_ax      (s_coord[0]),
        .s_ay      (s_coord[1]),
        .s_az      (s_coord[2]),
        .s_bx      (s_coord[3]),
        .s_by_coord(s_coord[4]),
        .s_bz      (s_coord[5]),
        .s_cx      (s_coord[6]),
        .s_cy      (s_coord[7]),
        .s_cz      (s_coord[8]),
        .s_px      (s_coord[9]),
        .s_py      (s_coord[10]),
        .s_pz      (s_coord[11]),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_near_x  (m_near_x),
        .m_near_y  (m_near_y),
        .m_near_z  (m_near_z),
        .m_region  (m_region)
    );

    // Clock
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    function automatic wide_t dot3(wide_t x [3], wide_t y [3]);
        return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
    endfunction

    // Round num/den to nearest, ties away from zero; den > 0
    function automatic wide_t round_div(wide_t num, wide_t den);
        wide_t mag;
        wide_t cap;
        cap = wide_t'(1) <<< 62;
        mag = ((num < 0 ? -num : num) * 2 + den) / (den * 2);
        if (mag >= cap) mag = cap;
        return num < 0 ? -mag : mag;
    endfunction

    function automatic logic [CW-1:0] clamp_coord(wide_t v);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (CW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[CW-1:0];
    endfunction

    // Closest point on triangle ABC to P, with the region that holds it
    function automatic near_pt_t closest_point(tri_req_t r);
        wide_t    a [3], b [3], c [3], p [3];
        wide_t    ab [3], ac [3], bc [3], ap [3], bp [3], cp [3];
        wide_t    pt [3];
        wide_t    d1, d2, d3, d4, d5, d6, va, vb, vc, e43, e56, den;
        near_pt_t res;
        for (int k = 0; k < 3; k++) begin
            a[k]  = r.v[k];
            b[k]  = r.v[3 + k];
            c[k]  = r.v[6 + k];
            p[k]  = r.v[9 + k];
            ab[k] = b[k] - a[k];
            ac[k] = c[k] - a[k];
            bc[k] = c[k] - b[k];
            ap[k] = p[k] - a[k];
            bp[k] = p[k] - b[k];
            cp[k] = p[k] - c[k];
            pt[k] = 0;
        end
        d1  = dot3(ab, ap);
        d2  = dot3(ac, ap);
        d3  = dot3(ab, bp);
        d4  = dot3(ac, bp);
        d5  = dot3(ab, cp);
        d6  = dot3(ac, cp);
        va  = d3 * d6 - d5 * d4;
        vb  = d5 * d2 - d1 * d6;
        vc  = d1 * d4 - d3 * d2;
        e43 = d4 - d3;
        e56 = d5 - d6;
        res.rgn = RGN_NONE;
        if (va >= 0 && vb >= 0 && vc >= 0) begin
            res.rgn = RGN_FACE;
            den = va + vb + vc;
            for (int k = 0; k < 3; k++) begin
                pt[k] = a[k];
                if (den > 0) pt[k] += round_div(vb * ab[k] + vc * ac[k], den);
            end
        end else if (d6 >= 0 && e56 <= 0) begin
            res.rgn = RGN_VERTEX;
            pt = c;
        end else if (d3 >= 0 && e43 <= 0) begin
            res.rgn = RGN_VERTEX;
            pt = b;
        end else if (d1 <= 0 && d2 <= 0) begin
            res.rgn = RGN_VERTEX;
            pt = a;
        end else if (va <= 0 && e43 >= 0 && e56 >= 0) begin
            res.rgn = RGN_EDGE;
            den = e43 + e56;
            for (int k = 0; k < 3; k++) begin
                pt[k] = b[k];
                if (den > 0) pt[k] += round_div(e43 * bc[k], den);
            end
        end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
            res.rgn = RGN_EDGE;
            den = d2 - d6;
            for (int k = 0; k < 3; k++) begin
                pt[k] = a[k];
                if (den > 0) pt[k] += round_div(d2 * ac[k], den);
            end
        end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
            res.rgn = RGN_EDGE;
            den = d1 - d3;
            for (int k = 0; k < 3; k++) begin
                pt[k] = a[k];
                if (den > 0) pt[k] += round_div(d1 * ab[k], den);
            end
        end
        res.x = clamp_coord(pt[0]);
        res.y = clamp_coord(pt[1]);
        res.z = clamp_coord(pt[2]);
        return res;
    endfunction

    // Queue a request given in whole units (Q16.16 integer part)
    task automatic add_units(int u [12]);
        tri_req_t r;
        for (int k = 0; k < 12; k++) r.v[k] = u[k] * 65536;
        r.drain_first = 0;
        pending_reqs.push_back(r);
    endtask

    function automatic logic signed [CW-1:0] rnd_span(int bits);
        logic signed [CW-1:0] v;
        v = $urandom;
        return v >>> (CW - bits);
    endfunction

    // Random request; most are triangles with P near them
    function automatic tri_req_t rand_req();
        tri_req_t r;
        int       kind;
        int       bits;
        int       mul;
        kind = $urandom_range(99);
        bits = $urandom_range(12, 24);
        r.drain_first = 0;
        for (int k = 0; k < 12; k++) r.v[k] = rnd_span(bits);
        if (kind < 12) begin
            for (int k = 0; k < 12; k++) r.v[k] = $urandom;
        end else if (kind < 18) begin
            // extreme coordinates
            for (int k = 0; k < 12; k++)
                r.v[k] = ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
        end else if (kind < 26) begin
            // collinear vertices
            mul = $urandom_range(0, 6) - 3;
            for (int k = 0; k < 3; k++) begin
                r.v[3 + k] = r.v[k] + rnd_span(bits - 2);
                r.v[6 + k] = r.v[k] + mul * (r.v[3 + k] - r.v[k]);
            end
        end else if (kind < 32) begin
            // two vertices shared
            for (int k = 0; k < 3; k++) r.v[3 * $urandom_range(1, 2) + k] = r.v[k];
        end else if (kind < 36) begin
            // all vertices equal
            for (int k = 0; k < 3; k++) begin
                r.v[3 + k] = r.v[k];
                r.v[6 + k] = r.v[k];
            end
        end
        return r;
    endfunction

    // Drive requests and record what each one must produce
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                tri_req_t cur;
                for (int k = 0; k < 12; k++) cur.v[k] = s_coord[k];
                expected_pts.push_back(closest_point(cur));
                n_sent++;
            end
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() == 0 ||
                    (pending_reqs[0].drain_first && expected_pts.size() != 0) ||
                    ((n_sent < 300 || n_sent > 500) && $urandom_range(99) < 9)) begin
                    s_valid <= 1'b0;
                end else begin
                    tri_req_t nxt;
                    nxt = pending_reqs.pop_front();
                    for (int k = 0; k < 12; k++) s_coord[k] <= nxt.v[k];
                    s_valid <= 1'b1;
                end
            end
        end
    end

    // Accept results and check them against the oldest expectation
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                near_pt_t exp_pt;
                n_recv++;
                if (expected_pts.size() == 0) begin
                    $error("unexpected result x=%h y=%h z=%h region=%0d",
                           m_near_x, m_near_y, m_near_z, m_region);
                    n_fail++;
                end else begin
                    exp_pt = expected_pts.pop_front();
                    if (m_near_x !== exp_pt.x) begin
                        $error("near_x expected %h actual %h", exp_pt.x, m_near_x);
                        n_fail++;
                    end
                    if (m_near_y !== exp_pt.y) begin
                        $error("near_y expected %h actual %h", exp_pt.y, m_near_y);
                        n_fail++;
                    end
                    if (m_near_z !== exp_pt.z) begin
                        $error("near_z expected %h actual %h", exp_pt.z, m_near_z);
                        n_fail++;
                    end
                    if (m_region !== exp_pt.rgn) begin
                        $error("region expected %0d actual %0d", exp_pt.rgn, m_region);
                        n_fail++;
                    end
                end
            end
            m_ready <= (n_recv >= 350 && n_recv <= 550) || ($urandom_range(99) >= 9);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_MAX) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        tri_req_t r;
        aresetn = 1'b0;

        // Right triangle in z=0; P in each region
        add_units('{0, 0, 0, 10, 0, 0, 0, 10, 0, 2, 2, 5});
        add_units('{0, 0, 0, 10, 0, 0, 0, 10, 0, -3, -3, 0});
        add_units('{0, 0, 0, 10, 0, 0, 0, 10, 0, 15, -1, 0});
        add_units('{0, 0, 0, 10, 0, 0, 0, 10, 0, -1, 15, 0});
        add_units('{0, 0, 0, 10, 0, 0, 0, 10, 0, 5, -5, 2});
        add_units('{0, 0, 0, 10, 0, 0, 0, 10, 0, -5, 5, -2});
        add_units('{0, 0, 0, 10, 0, 0, 0, 10, 0, 8, 8, 1});
        add_units('{0, 0, 0, 3, 0, 0, 0, 7, 0, 1, 1, 0});
        // Collapsed triangles: point, segment, collinear
        add_units('{4, 4, 4, 4, 4, 4, 4, 4, 4, 1, 2, 3});
        add_units('{0, 0, 0, 10, 0, 0, 10, 0, 0, 5, 3, 0});
        add_units('{0, 0, 0, 10, 0, 0, 20, 0, 0, 5, 3, 0});
        add_units('{0, 0, 0, 10, 0, 0, -10, 0, 0, 15, 3, 0});
        // Extremes of the coordinate range
        r.drain_first = 0;
        for (int k = 0; k < 12; k++) r.v[k] = 32'sh7fffffff;
        pending_reqs.push_back(r);
        for (int k = 0; k < 12; k++) r.v[k] = 32'sh80000000;
        pending_reqs.push_back(r);
        for (int k = 0; k < 12; k++) r.v[k] = (k % 2) ? 32'sh80000000 : 32'sh7fffffff;
        pending_reqs.push_back(r);
        for (int k = 0; k < 12; k++) r.v[k] = (k < 3 || k >= 9) ? 32'sh80000000 : 32'sh7fffffff;
        pending_reqs.push_back(r);
        for (int k = 0; k < 12; k++) r.v[k] = (k < 9) ? 32'sh7fff0000 : 32'sh80000000;
        r.v[3] = 32'sh80000000;
        pending_reqs.push_back(r);
        for (int k = 0; k < 12; k++) r.v[k] = 0;
        r.v[3] = 1; r.v[7] = 1; r.v[9] = 1; r.v[10] = 1;
        pending_reqs.push_back(r);

        // Random requests; one waits for the pipeline to drain
        for (int i = 0; i < 900; i++) begin
            r = rand_req();
            r.drain_first = (i == 450);
            pending_reqs.push_back(r);
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() != 0 || s_valid) @(posedge aclk);
        while (expected_pts.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (n_fail == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// File: files.f
design/cpt_pkg.sv
design/cpt_dly.sv
design/cpt_mul.sv
design/cpt_div.sv
design/closest_point_on_triangle.sv
bench/testbench.sv
